// ----- hw/rtl/multi_voice_pcm_mixer_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Mixer assertion macros
// Concurrent assertion wrappers; compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef MULTI_VOICE_PCM_MIXER_UNIT_DEFINES_SVH
`define MULTI_VOICE_PCM_MIXER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Plain property, reset disables the check.
`define MVPM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Same-cycle implication.
`define MVPM_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);
`else
`define MVPM_ASSERT(lbl, clk, rstn, prop, msg)
`define MVPM_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ----- hw/rtl/mvpm_pkg.sv -----
// ----------------------------------------------------------------------------
// Mixer package
// Shared operation codes, request type, sequencer states and saturation.
// ----------------------------------------------------------------------------
package mvpm_pkg;

  localparam logic [2:0] CMD_LOAD     = 3'd0;
  localparam logic [2:0] CMD_PLAY     = 3'd1;
  localparam logic [2:0] CMD_STOP     = 3'd2;
  localparam logic [2:0] CMD_STOP_ALL = 3'd3;
  localparam logic [2:0] CMD_TICK     = 3'd4;

  localparam int ACC_W       = 22;
  localparam int QUEUE_DEPTH = 2;

  localparam logic signed [ACC_W-1:0] ACC_MIN = ACC_W'(-32768);
  localparam logic signed [ACC_W-1:0] ACC_MAX = ACC_W'(32767);

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_PLAY,
    OP_STOP,
    OP_STOP_ALL,
    OP_TICK,
    OP_NONE
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [15:0]        address;
    logic signed [15:0] data_word;
    logic [16:0]        length;
    logic               stereo;
    logic               repeat_req;
    logic               notify;
    logic [2:0]         voice_select;
  } item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SLOT,
    S_ACC,
    S_DONE
  } back_state_e;

  function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] s);
    logic signed [15:0] r;
    if (s < ACC_MIN) begin
      r = 16'sh8000;
    end else if (s > ACC_MAX) begin
      r = 16'sh7fff;
    end else begin
      r = s[15:0];
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/mvpm_channels.sv -----
// ----------------------------------------------------------------------------
// Mixer channels
// Valid/ready interfaces for the request and result channels.
// ----------------------------------------------------------------------------
interface mvpm_cmd_if;
  logic               valid;
  logic               ready;
  logic [2:0]         command;
  logic [15:0]        address;
  logic signed [15:0] data_word;
  logic [16:0]        length;
  logic               stereo;
  logic               repeat_req;
  logic               notify;
  logic [2:0]         voice_select;

  modport source (output valid, command, address, data_word, length, stereo,
                  repeat_req, notify, voice_select, input ready);
  modport sink (input valid, command, address, data_word, length, stereo,
                repeat_req, notify, voice_select, output ready);
endinterface

interface mvpm_res_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left;
  logic signed [15:0] right;
  logic [2:0]         voice_index;
  logic               play_ok;
  logic [7:0]         ended_mask;

  modport source (output valid, left, right, voice_index, play_ok, ended_mask,
                  input ready);
  modport sink (input valid, left, right, voice_index, play_ok, ended_mask,
                output ready);
endinterface

// ----- hw/rtl/mvpm_front.sv -----
// ----------------------------------------------------------------------------
// Mixer front stage
// Register and classify incoming requests.
// ----------------------------------------------------------------------------
module mvpm_front import mvpm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  mvpm_cmd_if.sink  cmd_i,
  output logic      valid_o,
  output item_t     item_o,
  input  logic      ready_i
);

  logic  vld_q;
  item_t item_q, item_d;

  assign cmd_i.ready = !vld_q || ready_i;

  always_comb begin
    unique case (cmd_i.command)
      CMD_LOAD:     item_d.op = OP_LOAD;
      CMD_PLAY:     item_d.op = OP_PLAY;
      CMD_STOP:     item_d.op = OP_STOP;
      CMD_STOP_ALL: item_d.op = OP_STOP_ALL;
      CMD_TICK:     item_d.op = OP_TICK;
      default:      item_d.op = OP_NONE;
    endcase
    item_d.address      = cmd_i.address;
    item_d.data_word    = cmd_i.data_word;
    item_d.length       = cmd_i.length;
    item_d.stereo       = cmd_i.stereo;
    item_d.repeat_req   = cmd_i.repeat_req;
    item_d.notify       = cmd_i.notify;
    item_d.voice_select = cmd_i.voice_select;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (cmd_i.ready) begin
      vld_q <= cmd_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.valid && cmd_i.ready) begin
      item_q <= item_d;
    end
  end

  assign valid_o = vld_q;
  assign item_o  = item_q;

endmodule

// ----- hw/rtl/mvpm_queue.sv -----
// ----------------------------------------------------------------------------
// Mixer request queue
// Short FIFO decoupling the front stage from the execution sequencer.
// ----------------------------------------------------------------------------
module mvpm_queue import mvpm_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  input  item_t item_i,
  output logic  ready_o,
  output logic  valid_o,
  output item_t item_o,
  input  logic  ready_i
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  item_t         mem_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          push, pop;

  assign ready_o = (cnt_q != CW'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_q];
  assign push    = valid_i && ready_o;
  assign pop     = valid_o && ready_i;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= item_i;
    end
  end

endmodule

// ----- hw/rtl/mvpm_back.sv -----
// ----------------------------------------------------------------------------
// Mixer execution sequencer
// Voice table, sample memory, per-voice mix loop and result register.
// ----------------------------------------------------------------------------
module mvpm_back import mvpm_pkg::*; #(
  parameter int VOICE_COUNT  = 8,
  parameter int SAMPLE_WORDS = 65536
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  input  item_t      item_i,
  output logic       ready_o,
  mvpm_res_if.source res_o
);

  localparam int VW    = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
  localparam int VCW   = VW + 1;
  localparam int AW    = $clog2(SAMPLE_WORDS);
  localparam int SUM_W = (AW > 18) ? AW : 18;

  function automatic logic [7:0] end_bit(input int unsigned v, input logic ntf);
    logic [7:0] r;
    r = '0;
    if (ntf && v < 8) begin
      r[v[2:0]] = 1'b1;
    end
    return r;
  endfunction

  // voice table
  logic        act_q  [VOICE_COUNT];
  logic        act_d  [VOICE_COUNT];
  logic [15:0] start_q[VOICE_COUNT];
  logic [15:0] start_d[VOICE_COUNT];
  logic [16:0] len_q  [VOICE_COUNT];
  logic [16:0] len_d  [VOICE_COUNT];
  logic [16:0] pos_q  [VOICE_COUNT];
  logic [16:0] pos_d  [VOICE_COUNT];
  logic        ster_q [VOICE_COUNT];
  logic        ster_d [VOICE_COUNT];
  logic        loop_q [VOICE_COUNT];
  logic        loop_d [VOICE_COUNT];
  logic        ntf_q  [VOICE_COUNT];
  logic        ntf_d  [VOICE_COUNT];

  // sample memory
  logic [15:0] smem [SAMPLE_WORDS];
  logic [15:0] rd_q;
  logic        mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [15:0] mem_wdata;

  back_state_e state_q, state_d;
  logic [VCW-1:0] vc_q, vc_d;
  logic           slot_q, slot_d;
  logic signed [ACC_W-1:0] accl_q, accl_d, accr_q, accr_d;
  logic [7:0]     end_q, end_d;
  logic [2:0]     vidx_q, vidx_d;
  logic           ok_q, ok_d;

  logic               out_vld_q, out_vld_d;
  logic signed [15:0] out_l_q, out_l_d, out_r_q, out_r_d;
  logic [2:0]         out_vi_q, out_vi_d;
  logic               out_ok_q, out_ok_d;
  logic [7:0]         out_end_q, out_end_d;

  logic          free_found;
  logic [VW-1:0] free_idx;
  logic [VW-1:0] sel_idx, cur;
  logic [16:0]   rdpos;
  logic [SUM_W-1:0] sum;
  logic signed [ACC_W-1:0] wext;

  // lowest free voice
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int v = VOICE_COUNT - 1; v >= 0; v--) begin
      if (!act_q[v]) begin
        free_found = 1'b1;
        free_idx   = VW'(v);
      end
    end
  end

  assign ready_o = (state_q == S_IDLE);
  assign sel_idx = VW'(item_i.voice_select);
  assign cur     = vc_q[VW-1:0];
  assign wext    = ACC_W'($signed(rd_q));

  always_comb begin
    act_d   = act_q;
    start_d = start_q;
    len_d   = len_q;
    pos_d   = pos_q;
    ster_d  = ster_q;
    loop_d  = loop_q;
    ntf_d   = ntf_q;
    state_d = state_q;
    vc_d    = vc_q;
    slot_d  = slot_q;
    accl_d  = accl_q;
    accr_d  = accr_q;
    end_d   = end_q;
    vidx_d  = vidx_q;
    ok_d    = ok_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = AW'(item_i.address);
    mem_wdata = item_i.data_word;
    rdpos     = '0;
    sum       = '0;
    mem_raddr = '0;
    out_vld_d = out_vld_q && !res_o.ready;
    out_l_d   = out_l_q;
    out_r_d   = out_r_q;
    out_vi_d  = out_vi_q;
    out_ok_d  = out_ok_q;
    out_end_d = out_end_q;

    unique case (state_q)
      S_IDLE: begin
        if (valid_i) begin
          accl_d  = '0;
          accr_d  = '0;
          end_d   = '0;
          vidx_d  = '0;
          ok_d    = 1'b0;
          state_d = S_DONE;
          unique case (item_i.op)
            OP_LOAD: begin
              mem_we = 1'b1;
            end
            OP_PLAY: begin
              if (free_found) begin
                act_d[free_idx]   = 1'b1;
                start_d[free_idx] = item_i.address;
                len_d[free_idx]   = item_i.length;
                pos_d[free_idx]   = '0;
                ster_d[free_idx]  = item_i.stereo;
                loop_d[free_idx]  = item_i.repeat_req;
                ntf_d[free_idx]   = item_i.notify;
                vidx_d            = 3'(free_idx);
                ok_d              = 1'b1;
              end
            end
            OP_STOP: begin
              if (32'(item_i.voice_select) < VOICE_COUNT) begin
                if (act_q[sel_idx]) begin
                  end_d          = end_bit(32'(item_i.voice_select), ntf_q[sel_idx]);
                  act_d[sel_idx] = 1'b0;
                end
              end
            end
            OP_STOP_ALL: begin
              for (int v = 0; v < VOICE_COUNT; v++) begin
                if (act_q[v]) begin
                  end_d = end_d | end_bit(v, ntf_q[v]);
                end
                act_d[v] = 1'b0;
              end
            end
            OP_TICK: begin
              vc_d    = '0;
              slot_d  = 1'b0;
              state_d = S_SLOT;
            end
            default: ;
          endcase
        end
      end
      S_SLOT: begin
        if (vc_q == VCW'(VOICE_COUNT)) begin
          state_d = S_DONE;
        end else if (!act_q[cur]) begin
          vc_d = vc_q + 1'b1;
        end else if (pos_q[cur] >= len_q[cur] &&
                     !(loop_q[cur] && len_q[cur] != '0)) begin
          // voice ran out: drop it and flag it
          act_d[cur] = 1'b0;
          end_d      = end_q | end_bit(32'(cur), ntf_q[cur]);
          vc_d       = vc_q + 1'b1;
          slot_d     = 1'b0;
        end else begin
          rdpos      = (pos_q[cur] >= len_q[cur]) ? '0 : pos_q[cur];
          sum        = SUM_W'(start_q[cur]) + SUM_W'(rdpos);
          mem_raddr  = sum[AW-1:0];
          mem_re     = 1'b1;
          pos_d[cur] = rdpos + 1'b1;
          state_d    = S_ACC;
        end
      end
      S_ACC: begin
        state_d = S_SLOT;
        if (ster_q[cur]) begin
          if (!slot_q) begin
            accl_d = accl_q + wext;
            slot_d = 1'b1;
          end else begin
            accr_d = accr_q + wext;
            slot_d = 1'b0;
            vc_d   = vc_q + 1'b1;
          end
        end else begin
          accl_d = accl_q + wext;
          accr_d = accr_q + wext;
          vc_d   = vc_q + 1'b1;
        end
      end
      S_DONE: begin
        if (!out_vld_q || res_o.ready) begin
          out_vld_d = 1'b1;
          out_l_d   = sat16(accl_q);
          out_r_d   = sat16(accr_q);
          out_vi_d  = vidx_q;
          out_ok_d  = ok_q;
          out_end_d = end_q;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      out_vld_q <= 1'b0;
      for (int v = 0; v < VOICE_COUNT; v++) begin
        act_q[v] <= 1'b0;
      end
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      act_q     <= act_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q   <= start_d;
    len_q     <= len_d;
    pos_q     <= pos_d;
    ster_q    <= ster_d;
    loop_q    <= loop_d;
    ntf_q     <= ntf_d;
    vc_q      <= vc_d;
    slot_q    <= slot_d;
    accl_q    <= accl_d;
    accr_q    <= accr_d;
    end_q     <= end_d;
    vidx_q    <= vidx_d;
    ok_q      <= ok_d;
    out_l_q   <= out_l_d;
    out_r_q   <= out_r_d;
    out_vi_q  <= out_vi_d;
    out_ok_q  <= out_ok_d;
    out_end_q <= out_end_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      smem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= smem[mem_raddr];
    end
  end

  assign res_o.valid       = out_vld_q;
  assign res_o.left        = out_l_q;
  assign res_o.right       = out_r_q;
  assign res_o.voice_index = out_vi_q;
  assign res_o.play_ok     = out_ok_q;
  assign res_o.ended_mask  = out_end_q;

endmodule

// ----- hw/rtl/multi_voice_pcm_mixer_unit.sv -----
// ----------------------------------------------------------------------------
// Multi-voice PCM mixer
// Sample store, voice table and saturating stereo mix behind two channels.
// ----------------------------------------------------------------------------
// Usage:
//   cmd_i carries one request per valid/ready handshake: load a sample word,
//   play, stop a voice, stop all voices, or tick. res_o returns exactly one
//   result per request, in order, on its own valid/ready handshake.
//   A request passes a front register and a two-entry queue, then the
//   sequencer runs it. Load, play, stop and stop-all go from the idle state
//   through the done state to the output register. A tick walks the voice
//   table one voice at a time through the single sample memory read port:
//   an idle voice is skipped, a mono voice takes one read and a stereo voice
//   two, each read followed by an accumulate step before the next.
//   When res_o stalls, the finished result holds in the output register,
//   the sequencer parks the next result, and the queue keeps taking
//   requests until full; then cmd_i.ready drops.
//   Reset clears all voices and empties the queue; the sample store is not
//   cleared, so read only words that were loaded.
// ----------------------------------------------------------------------------
`include "multi_voice_pcm_mixer_unit_defines.svh"

module multi_voice_pcm_mixer_unit import mvpm_pkg::*; #(
  parameter int VOICE_COUNT  = 8,
  parameter int SAMPLE_WORDS = 65536
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mvpm_cmd_if.sink   cmd_i,
  mvpm_res_if.source res_o
);

  // front stage to queue
  logic  f_vld, f_rdy;
  item_t f_item;
  // queue to sequencer
  logic  q_vld, q_rdy;
  item_t q_item;

  // Register and classify each request.
  mvpm_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd_i),
    .valid_o (f_vld),
    .item_o  (f_item),
    .ready_i (f_rdy)
  );

  // Hold pending requests while the sequencer mixes.
  mvpm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (f_vld),
    .item_i  (f_item),
    .ready_o (f_rdy),
    .valid_o (q_vld),
    .item_o  (q_item),
    .ready_i (q_rdy)
  );

  // Execute requests and drive the result register.
  mvpm_back #(
    .VOICE_COUNT  (VOICE_COUNT),
    .SAMPLE_WORDS (SAMPLE_WORDS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (q_vld),
    .item_i  (q_item),
    .ready_o (q_rdy),
    .res_o   (res_o)
  );

  // Front stage must hold its request while the queue is full.
  `MVPM_ASSERT(a_front_hold, clk_i, rst_ni, (f_vld && !f_rdy) |=> f_vld, "front dropped request")
  // A successful play reports no mix and no ended voices.
  `MVPM_ASSERT_IMP(a_play_clean, clk_i, rst_ni, res_o.valid && res_o.play_ok, res_o.ended_mask == 8'd0 && res_o.left == 16'sd0 && res_o.right == 16'sd0, "play result carries mix data")
  // A nonzero mix only comes from a tick, which never claims a voice.
  `MVPM_ASSERT_IMP(a_mix_tick, clk_i, rst_ni, res_o.valid && (res_o.left != 16'sd0 || res_o.right != 16'sd0), !res_o.play_ok && res_o.voice_index == 3'd0, "mix result claims a voice")

endmodule

// ----- test/multi_voice_pcm_mixer_unit_tb.sv -----
// ----------------------------------------------------------------------------
// Multi-voice PCM mixer testbench
// Drives load, play, stop, stop-all and tick requests through the request
// channel and checks every result against an in-bench mixer prediction,
// with random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multi_voice_pcm_mixer_unit_tb;
  import mvpm_pkg::*;

  typedef struct packed {
    logic [2:0]         command;
    logic [15:0]        address;
    logic signed [15:0] data_word;
    logic [16:0]        length;
    logic               stereo;
    logic               repeat_req;
    logic               notify;
    logic [2:0]         voice_select;
  } request_t;

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic [2:0]         voice_index;
    logic               play_ok;
    logic [7:0]         ended_mask;
  } mix_result_t;

  logic clk_i;
  logic rst_ni;

  mvpm_cmd_if cmd_if ();
  mvpm_res_if res_if ();

  multi_voice_pcm_mixer_unit i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_if.sink),
    .res_o (res_if.source)
  );

  // Predictor state: mirror of the voice table and the sample store.
  logic [15:0] pcm_store [int];
  logic        vc_active [8];
  logic [15:0] vc_start  [8];
  logic [16:0] vc_length [8];
  logic [16:0] vc_pos    [8];
  logic        vc_stereo [8];
  logic        vc_loops  [8];
  logic        vc_notify [8];

  request_t    pending_requests[$];
  mix_result_t expected_results[$];

  int  send_idle_pct;
  int  recv_idle_pct;
  int  error_count;

  // Fetch one slot of voice v; return 0 when the voice has ended.
  function automatic bit fetch_slot(int v, output int word);
    logic [15:0] raw;
    word = 0;
    if (vc_pos[v] >= vc_length[v]) begin
      if (!vc_loops[v] || vc_length[v] == 0) return 0;
      vc_pos[v] = 0;
    end
    raw  = pcm_store.exists(16'(vc_start[v] + vc_pos[v])) ?
           pcm_store[16'(vc_start[v] + vc_pos[v])] : 16'h0;
    word = $signed(raw);
    vc_pos[v] = vc_pos[v] + 1;
    return 1;
  endfunction

  function automatic logic signed [15:0] clip16(int s);
    if (s < -32768) return 16'sh8000;
    if (s > 32767) return 16'sh7fff;
    return 16'(s);
  endfunction

  // Advance the mirror by one request and return the predicted result.
  function automatic mix_result_t mix_predict(request_t rq);
    mix_result_t r;
    int sl, sr, w;
    bit alive;
    r = '0;
    sl = 0;
    sr = 0;
    case (rq.command)
      CMD_LOAD: pcm_store[rq.address] = rq.data_word;
      CMD_PLAY: begin
        for (int v = 0; v < 8; v++) begin
          if (!vc_active[v]) begin
            vc_active[v] = 1;
            vc_start[v]  = rq.address;
            vc_length[v] = rq.length;
            vc_pos[v]    = 0;
            vc_stereo[v] = rq.stereo;
            vc_loops[v]  = rq.repeat_req;
            vc_notify[v] = rq.notify;
            r.voice_index = 3'(v);
            r.play_ok = 1;
            break;
          end
        end
      end
      CMD_STOP: begin
        if (vc_active[rq.voice_select]) begin
          r.ended_mask[rq.voice_select] = vc_notify[rq.voice_select];
          vc_active[rq.voice_select] = 0;
        end
      end
      CMD_STOP_ALL: begin
        for (int v = 0; v < 8; v++) begin
          if (vc_active[v]) r.ended_mask[v] = vc_notify[v];
          vc_active[v] = 0;
        end
      end
      CMD_TICK: begin
        for (int v = 0; v < 8; v++) begin
          if (!vc_active[v]) continue;
          alive = fetch_slot(v, w);
          if (alive) begin
            sl += w;
            if (vc_stereo[v]) begin
              alive = fetch_slot(v, w);
              if (alive) sr += w;
            end else begin
              sr += w;
            end
          end
          if (!alive) begin
            r.ended_mask[v] = vc_notify[v];
            vc_active[v] = 0;
          end
        end
        r.left  = clip16(sl);
        r.right = clip16(sr);
      end
      default: ;
    endcase
    return r;
  endfunction

  // Only addresses that were loaded may be played; sounds sit in one
  // loaded region so every read hits a written word.
  localparam int REGION_BASE = 16'hFFC0;
  localparam int REGION_SIZE = 128;

  function automatic request_t blank_request(logic [2:0] cmd);
    request_t rq;
    rq = '0;
    rq.command = cmd;
    return rq;
  endfunction

  function automatic request_t load_request(logic [15:0] a, logic [15:0] d);
    request_t rq;
    rq = blank_request(CMD_LOAD);
    rq.address   = a;
    rq.data_word = d;
    return rq;
  endfunction

  function automatic request_t play_request(int offs, int len, bit st, bit rp,
                                            bit nt);
    request_t rq;
    rq = blank_request(CMD_PLAY);
    rq.address    = 16'(REGION_BASE + offs);
    rq.length     = 17'(len);
    rq.stereo     = st;
    rq.repeat_req = rp;
    rq.notify     = nt;
    return rq;
  endfunction

  // Random request with random content in the fields a command ignores.
  function automatic request_t random_request();
    request_t rq;
    int pick;
    int offs;
    int len;
    rq = request_t'(58'({$urandom, $urandom}));
    pick = $urandom_range(0, 99);
    offs = $urandom_range(0, REGION_SIZE - 1);
    if (pick < 15) begin
      rq.command = CMD_LOAD;
      rq.address = 16'(REGION_BASE + offs);
    end else if (pick < 35) begin
      rq.command = CMD_PLAY;
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 1) :
            $urandom_range(1, REGION_SIZE - offs);
      rq.address = 16'(REGION_BASE + offs);
      rq.length  = 17'(len);
      if (!rq.repeat_req && $urandom_range(0, 3) == 0) begin
        // Now and then, stretch a non-looping sound to the end of the region.
        rq.length = 17'(REGION_SIZE - offs);
      end
    end else if (pick < 42) begin
      rq.command = CMD_STOP;
    end else if (pick < 45) begin
      rq.command = CMD_STOP_ALL;
    end else if (pick < 97) begin
      rq.command = CMD_TICK;
    end else begin
      rq.command = 3'($urandom_range(5, 7));
    end
    return rq;
  endfunction

  // Clock.
  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // Request driver: advance to the next pending request after a handshake.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_if.valid <= 0;
      cmd_if.command <= '0;
      cmd_if.address <= '0;
      cmd_if.data_word <= '0;
      cmd_if.length <= '0;
      cmd_if.stereo <= 0;
      cmd_if.repeat_req <= 0;
      cmd_if.notify <= 0;
      cmd_if.voice_select <= '0;
    end else if (!cmd_if.valid || cmd_if.ready) begin
      if (pending_requests.size() > 0 &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        request_t rq;
        rq = pending_requests.pop_front();
        expected_results.push_back(mix_predict(rq));
        cmd_if.valid <= 1;
        cmd_if.command <= rq.command;
        cmd_if.address <= rq.address;
        cmd_if.data_word <= rq.data_word;
        cmd_if.length <= rq.length;
        cmd_if.stereo <= rq.stereo;
        cmd_if.repeat_req <= rq.repeat_req;
        cmd_if.notify <= rq.notify;
        cmd_if.voice_select <= rq.voice_select;
      end else begin
        cmd_if.valid <= 0;
      end
    end
  end

  // Result monitor: compare each accepted result with the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (expected_results.size() == 0) begin
          $error("result with no request outstanding");
          error_count++;
        end else begin
          mix_result_t e;
          e = expected_results.pop_front();
          if (res_if.left !== e.left) begin
            $error("left: expected %0d, got %0d", e.left, res_if.left);
            error_count++;
          end
          if (res_if.right !== e.right) begin
            $error("right: expected %0d, got %0d", e.right, res_if.right);
            error_count++;
          end
          if (res_if.voice_index !== e.voice_index) begin
            $error("voice_index: expected %0d, got %0d", e.voice_index,
                   res_if.voice_index);
            error_count++;
          end
          if (res_if.play_ok !== e.play_ok) begin
            $error("play_ok: expected %0d, got %0d", e.play_ok, res_if.play_ok);
            error_count++;
          end
          if (res_if.ended_mask !== e.ended_mask) begin
            $error("ended_mask: expected %h, got %h", e.ended_mask,
                   res_if.ended_mask);
            error_count++;
          end
        end
      end
      res_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Stimulus and end of run.
  initial begin
    int waited;
    error_count = 0;
    send_idle_pct = 37;
    recv_idle_pct = 72;
    for (int v = 0; v < 8; v++) begin
      vc_active[v] = 0; vc_start[v] = 0; vc_length[v] = 0; vc_pos[v] = 0;
      vc_stereo[v] = 0; vc_loops[v] = 0; vc_notify[v] = 0;
    end
    rst_ni = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;

    // Fill the sound region: extremes first so sums saturate both ways.
    for (int i = 0; i < REGION_SIZE; i++) begin
      logic [15:0] d;
      d = (i < 8) ? 16'h7fff : (i < 16) ? 16'h8000 : 16'($urandom);
      pending_requests.push_back(load_request(16'(REGION_BASE + i), d));
    end
    // Directed: wrap of the top address, every command, edge cases.
    pending_requests.push_back(load_request(16'h0000, 16'h1234));
    pending_requests.push_back(play_request(0, 8, 0, 0, 1));   // saturate up
    pending_requests.push_back(play_request(0, 8, 1, 0, 1));
    pending_requests.push_back(play_request(8, 8, 0, 1, 1));   // saturate down mix
    pending_requests.push_back(play_request(8, 3, 1, 1, 0));   // odd stereo loop
    pending_requests.push_back(play_request(0, 0, 0, 1, 1));   // zero length loop
    pending_requests.push_back(play_request(63, 65, 1, 0, 1)); // wraps to addr 0
    pending_requests.push_back(play_request(20, 1, 0, 0, 1));
    pending_requests.push_back(play_request(21, 2, 1, 1, 1));  // table now full
    pending_requests.push_back(play_request(22, 2, 1, 1, 1));  // play rejected
    repeat (4) pending_requests.push_back(blank_request(CMD_TICK));
    begin
      request_t rq;
      rq = blank_request(CMD_STOP);
      rq.voice_select = 3'd7;
      pending_requests.push_back(rq);
      pending_requests.push_back(rq);                          // stop free voice
    end
    pending_requests.push_back(blank_request(3'd5));
    pending_requests.push_back(blank_request(3'd7));
    pending_requests.push_back(blank_request(CMD_STOP_ALL));
    pending_requests.push_back(blank_request(CMD_TICK));        // empty mix

    // Random phases with the idling patterns swapped, then none.
    for (int phase = 0; phase < 3; phase++) begin
      for (int i = 0; i < 184; i++) pending_requests.push_back(random_request());
      while (pending_requests.size() > 0) @(posedge clk_i);
      send_idle_pct = (phase == 0) ? 72 : 0;
      recv_idle_pct = (phase == 0) ? 37 : 0;
    end
    waited = 0;
    while ((expected_results.size() > 0 || cmd_if.valid) && waited < 200000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (100) @(posedge clk_i);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog: hold off a hung run.
  initial begin
    #5ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
